@@ design/qcd_pkg.sv @@
package qcd_pkg;

    // Field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int THRESH_W   = 42;
    localparam int CFG_DATA_W = 42;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PASSTHROUGH = 2'd1;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 42'd100000;

    // Result kinds
    localparam logic RESULT_STATUS = 1'b0;
    localparam logic RESULT_RECORD = 1'b1;

    // Handshake from the energy unit back to the sequencer
    typedef struct packed {
        logic done;
        logic detected;
    } energy_status_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_UPDATE = 5'b00010,
        ST_ENERGY = 5'b00100,
        ST_STATUS = 5'b01000,
        ST_RECORD = 5'b10000
    } state_t;

endpackage

@@ design/qcd_energy.sv @@
module qcd_energy #(
    parameter int ACC_W = 22
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [ACC_W-1:0]           zc,
    input  logic signed [ACC_W-1:0]           zs,
    input  logic [qcd_pkg::THRESH_W-1:0]      threshold,
    output qcd_pkg::energy_status_t           status
);

    localparam int SQ_W  = 2 * ACC_W - 1;
    localparam int SUM_W = 2 * ACC_W;
    localparam int CMP_W = (SUM_W > qcd_pkg::THRESH_W) ? SUM_W : qcd_pkg::THRESH_W;

    logic [3:0]                 stage_reg;
    logic [3:0]                 stage_next;
    logic signed [ACC_W-1:0]    mul_op;
    logic signed [2*ACC_W-1:0]  prod;
    logic [SQ_W-1:0]            sqc_reg;
    logic [SQ_W-1:0]            sqs_reg;
    logic [SUM_W-1:0]           sum;
    logic                       det_reg;
    logic                       det_next;

    // One shared multiplier: cosine term first, sine term next
    assign mul_op = stage_reg[0] ? zc : zs;
    assign prod   = mul_op * mul_op;

    assign sum      = SUM_W'(sqc_reg) + SUM_W'(sqs_reg);
    assign det_next = CMP_W'(sum) > CMP_W'(threshold);

    // Advance the step marker
    assign stage_next = {stage_reg[2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            det_reg   <= 1'b0;
        end
        else
        begin
            stage_reg <= stage_next;
            if (stage_reg[2])
            begin
                det_reg <= det_next;
            end
        end
    end

    // Hold the squares
    always_ff @(posedge clk)
    begin
        if (stage_reg[0])
        begin
            sqc_reg <= prod[SQ_W-1:0];
        end
        if (stage_reg[1])
        begin
            sqs_reg <= prod[SQ_W-1:0];
        end
    end

    assign status.done     = stage_reg[3];
    assign status.detected = det_reg;

endmodule

@@ design/quadrature_correlation_detector_core.sv @@
// Channel   | Handshake                  | Payload
// ----------+----------------------------+--------------------------------------------
// input     | in_valid / in_ready        | sample_in
// output    | out_valid / out_ready      | result_kind, sample_out, detected, last_record
// config    | cfg_we (no wait)           | cfg_index, cfg_data
//
// A sample reaches its status transaction through one window memory read, one
// read-modify-write of the running correlation sums, and four steps of the shared
// squaring multiplier and energy compare. On detection, WINDOW record transactions
// follow one per cycle unless the output stalls, set by the single memory read port.
// Reset clears the window at once through per-slot valid bits. A stalled output holds the
// sequencer; a new sample is taken while the last record waits in the output register.
module quadrature_correlation_detector_core #(
    parameter int WINDOW = 40
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [qcd_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                result_kind,
    output logic signed [qcd_pkg::SAMPLE_W-1:0] sample_out,
    output logic                                detected,
    output logic                                last_record,
    input  logic                                cfg_we,
    input  logic [qcd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [qcd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int SW    = qcd_pkg::SAMPLE_W;
    localparam int IDX_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int ACC_W = SW + $clog2((WINDOW + 1) / 2) + 1;

    qcd_pkg::state_t                 state_reg;
    qcd_pkg::state_t                 state_next;

    logic [qcd_pkg::THRESH_W-1:0]    thresh_reg;
    logic                            pass_reg;

    logic [IDX_W-1:0]                pos_reg;
    logic [IDX_W-1:0]                pos_next;
    logic [IDX_W-1:0]                pos_inc;
    logic signed [ACC_W-1:0]         zc_reg;
    logic signed [ACC_W-1:0]         zc_next;
    logic signed [ACC_W-1:0]         zs_reg;
    logic signed [ACC_W-1:0]         zs_next;
    logic signed [SW-1:0]            smp_reg;

    // Window memory and its valid bits
    logic signed [SW-1:0]            window_mem [WINDOW];
    logic [WINDOW-1:0]               slot_valid_reg;
    logic [IDX_W-1:0]                rd_addr;
    logic                            rd_en;
    logic signed [SW-1:0]            rd_data_reg;
    logic                            rd_valid_reg;
    logic                            mem_we;
    logic [IDX_W-1:0]                mem_waddr;
    logic signed [SW-1:0]            mem_wdata;
    logic signed [SW-1:0]            old_smp;
    logic signed [SW:0]              diff;
    logic signed [ACC_W-1:0]         diff_ext;

    // Record walk
    logic [IDX_W-1:0]                rec_addr_reg;
    logic [IDX_W-1:0]                rec_addr_next;
    logic [IDX_W-1:0]                rec_inc;
    logic [CNT_W-1:0]                rec_cnt_reg;
    logic [CNT_W-1:0]                rec_cnt_next;
    logic                            pend_reg;
    logic                            pend_next;
    logic                            can_load;
    logic                            rec_issue;
    logic                            rec_consume;
    logic                            rec_last;

    // Output register
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            out_load;
    logic                            out_kind_reg;
    logic                            out_kind_next;
    logic signed [SW-1:0]            out_smp_reg;
    logic signed [SW-1:0]            out_smp_next;
    logic                            out_det_reg;
    logic                            out_det_next;
    logic                            out_last_reg;
    logic                            out_last_next;

    logic                            in_accept;
    logic                            energy_start;
    qcd_pkg::energy_status_t         energy_status;

    assign in_ready  = (state_reg == qcd_pkg::ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign can_load  = !out_valid_reg || out_ready;

    assign pos_inc = (pos_reg == IDX_W'(WINDOW - 1)) ? '0 : pos_reg + 1'b1;
    assign rec_inc = (rec_addr_reg == IDX_W'(WINDOW - 1)) ? '0 : rec_addr_reg + 1'b1;

    // Slot read: current write slot, or the record walk address
    assign rd_addr = (state_reg == qcd_pkg::ST_RECORD) ? rec_addr_reg : pos_reg;

    // Old slot value, never-written slots read as zero
    assign old_smp  = rd_valid_reg ? rd_data_reg : '0;
    assign diff     = {smp_reg[SW-1], smp_reg} - {old_smp[SW-1], old_smp};
    assign diff_ext = ACC_W'(diff);

    assign rec_consume = (state_reg == qcd_pkg::ST_RECORD) && pend_reg && can_load;
    assign rec_issue   = (state_reg == qcd_pkg::ST_RECORD) &&
                         (rec_cnt_reg != CNT_W'(WINDOW)) && (!pend_reg || can_load);
    assign rec_last    = (rec_cnt_reg == CNT_W'(WINDOW));

    // Hold the pending record slot while the output stalls
    assign rd_en = (state_reg != qcd_pkg::ST_RECORD) || rec_issue;

    assign energy_start = (state_reg == qcd_pkg::ST_UPDATE);

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        zc_next        = zc_reg;
        zs_next        = zs_reg;
        rec_addr_next  = rec_addr_reg;
        rec_cnt_next   = rec_cnt_reg;
        pend_next      = pend_reg;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg;
        mem_wdata      = smp_reg;
        out_load       = 1'b0;
        out_kind_next  = qcd_pkg::RESULT_STATUS;
        out_smp_next   = '0;
        out_det_next   = 1'b0;
        out_last_next  = 1'b0;

        case (state_reg)
            qcd_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = qcd_pkg::ST_UPDATE;
                end
            end
            qcd_pkg::ST_UPDATE:
            begin
                // Write the sample back and fold its change into one sum
                mem_we = 1'b1;
                if (pos_reg[0])
                begin
                    zs_next = pos_reg[1] ? zs_reg - diff_ext : zs_reg + diff_ext;
                end
                else
                begin
                    zc_next = pos_reg[1] ? zc_reg - diff_ext : zc_reg + diff_ext;
                end
                state_next = qcd_pkg::ST_ENERGY;
            end
            qcd_pkg::ST_ENERGY:
            begin
                if (energy_status.done)
                begin
                    state_next = qcd_pkg::ST_STATUS;
                end
            end
            qcd_pkg::ST_STATUS:
            begin
                if (can_load)
                begin
                    out_load      = 1'b1;
                    out_kind_next = qcd_pkg::RESULT_STATUS;
                    out_smp_next  = pass_reg ? smp_reg : '0;
                    out_det_next  = energy_status.detected;
                    if (energy_status.detected)
                    begin
                        // Window gets cleared by the walk, sums drop to zero
                        zc_next       = '0;
                        zs_next       = '0;
                        rec_addr_next = pos_inc;
                        rec_cnt_next  = '0;
                        pend_next     = 1'b0;
                        state_next    = qcd_pkg::ST_RECORD;
                    end
                    else
                    begin
                        pos_next   = pos_inc;
                        state_next = qcd_pkg::ST_IDLE;
                    end
                end
            end
            qcd_pkg::ST_RECORD:
            begin
                if (rec_consume)
                begin
                    out_load      = 1'b1;
                    out_kind_next = qcd_pkg::RESULT_RECORD;
                    out_smp_next  = old_smp;
                    out_det_next  = 1'b1;
                    out_last_next = rec_last;
                    if (rec_last)
                    begin
                        state_next = qcd_pkg::ST_IDLE;
                    end
                end
                // Read the next slot and zero it behind the read
                if (rec_issue)
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = rec_addr_reg;
                    mem_wdata     = '0;
                    rec_addr_next = rec_inc;
                    rec_cnt_next  = rec_cnt_reg + 1'b1;
                    pend_next     = 1'b1;
                end
                else if (rec_consume)
                begin
                    pend_next = 1'b0;
                end
            end
            default:
            begin
                state_next = qcd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= qcd_pkg::ST_IDLE;
            pos_reg        <= '0;
            zc_reg         <= '0;
            zs_reg         <= '0;
            rec_addr_reg   <= '0;
            rec_cnt_reg    <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            slot_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            zc_reg        <= zc_next;
            zs_reg        <= zs_next;
            rec_addr_reg  <= rec_addr_next;
            rec_cnt_reg   <= rec_cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (rd_en)
            begin
                rd_valid_reg <= slot_valid_reg[rd_addr];
            end
            if (mem_we)
            begin
                slot_valid_reg[mem_waddr] <= 1'b1;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= qcd_pkg::THRESH_RESET;
            pass_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == qcd_pkg::REG_THRESHOLD)
            begin
                thresh_reg <= cfg_data[qcd_pkg::THRESH_W-1:0];
            end
            else if (cfg_index == qcd_pkg::REG_PASSTHROUGH)
            begin
                pass_reg <= cfg_data[0];
            end
        end
    end

    // Window memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            window_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= window_mem[rd_addr];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            smp_reg <= sample_in;
        end
        if (out_load)
        begin
            out_kind_reg <= out_kind_next;
            out_smp_reg  <= out_smp_next;
            out_det_reg  <= out_det_next;
            out_last_reg <= out_last_next;
        end
    end

    qcd_energy #(
        .ACC_W (ACC_W)
    ) u_energy (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (energy_start),
        .zc        (zc_reg),
        .zs        (zs_reg),
        .threshold (thresh_reg),
        .status    (energy_status)
    );

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign sample_out  = out_smp_reg;
    assign detected    = out_det_reg;
    assign last_record = out_last_reg;

endmodule

@@ design/qcd_checker.sv @@
module qcd_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic                                result_kind,
    input logic signed [qcd_pkg::SAMPLE_W-1:0] sample_out,
    input logic                                detected,
    input logic                                last_record
);

    // Stalled output transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out) &&
        $stable(result_kind) && $stable(detected) && $stable(last_record))
    else $error("stalled output transaction changed");

    // Status transactions never carry the last-record mark
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == qcd_pkg::RESULT_STATUS) |-> !last_record)
    else $error("last_record set on a status transaction");

    // Record transactions only follow a detection
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == qcd_pkg::RESULT_RECORD) |-> detected)
    else $error("record transaction without detected");

    // One sample at a time: input closes after a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input still open right after a transaction");

endmodule

bind quadrature_correlation_detector_core qcd_checker u_qcd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .sample_out  (sample_out),
    .detected    (detected),
    .last_record (last_record)
);

@@ bench/quadrature_correlation_detector_checker.sv @@
`timescale 1ns / 1ps

module quadrature_correlation_detector_checker #(
    parameter int WINDOW = 40
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic signed [qcd_pkg::SAMPLE_W-1:0] sample_in,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                result_kind,
    input  logic signed [qcd_pkg::SAMPLE_W-1:0] sample_out,
    input  logic                                detected,
    input  logic                                last_record,
    input  logic                                cfg_we,
    input  logic [qcd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [qcd_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                  mismatch_count,
    output int                                  outstanding
);
    import qcd_pkg::*;

    typedef struct packed {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] smp;
        logic                       det;
        logic                       last;
    } detector_result_t;

    // Shadow of the detector state and registers
    logic signed [SAMPLE_W-1:0] window_copy [WINDOW];
    int unsigned                write_slot;
    logic [THRESH_W-1:0]        threshold_copy;
    logic                       echo_on;
    detector_result_t           pending_results [$];

    // Store the sample, correlate the window and queue the status and any record burst
    task automatic absorb_sample(input logic signed [SAMPLE_W-1:0] smp);
        longint           corr_c;
        longint           corr_s;
        logic [63:0]      energy;
        logic             hit;
        int unsigned      slot;
        detector_result_t r;
        corr_c = 0;
        corr_s = 0;
        window_copy[write_slot] = smp;
        for (int i = 0; i < WINDOW; i++)
        begin
            case (i % 4)
                0:       corr_c += window_copy[i];
                1:       corr_s += window_copy[i];
                2:       corr_c -= window_copy[i];
                default: corr_s -= window_copy[i];
            endcase
        end
        energy = corr_c * corr_c + corr_s * corr_s;
        hit = energy > {{(64 - THRESH_W){1'b0}}, threshold_copy};

        r.kind = RESULT_STATUS;
        r.smp  = echo_on ? smp : '0;
        r.det  = hit;
        r.last = 1'b0;
        pending_results.push_back(r);

        if (hit)
        begin
            // Emit oldest-first starting after the write slot, clearing as we go
            slot = write_slot;
            for (int n = 0; n < WINDOW; n++)
            begin
                slot = (slot + 1) % WINDOW;
                r.kind = RESULT_RECORD;
                r.smp  = window_copy[slot];
                r.det  = 1'b1;
                r.last = (n == WINDOW - 1);
                pending_results.push_back(r);
                window_copy[slot] = '0;
            end
        end
        else
        begin
            write_slot = (write_slot + 1) % WINDOW;
        end
    endtask

    // Compare one output transaction with the oldest expectation
    task automatic check_result();
        detector_result_t want;
        detector_result_t got;
        got.kind = result_kind;
        got.smp  = sample_out;
        got.det  = detected;
        got.last = last_record;
        if (pending_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("[%0t] unexpected result: kind=%0d sample=%0d detected=%0d last=%0d",
                         $time, got.kind, got.smp, got.det, got.last);
        end
        else
        begin
            want = pending_results.pop_front();
            if (got !== want)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display({"[%0t] result mismatch: expected kind=%0d sample=%0d ",
                              "detected=%0d last=%0d, got kind=%0d sample=%0d ",
                              "detected=%0d last=%0d"},
                             $time, want.kind, want.smp, want.det, want.last,
                             got.kind, got.smp, got.det, got.last);
            end
        end
    endtask

    // Track register writes, predict on input transactions, check output transactions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
                window_copy[i] = '0;
            write_slot     = 0;
            threshold_copy = THRESH_RESET;
            echo_on        = 1'b0;
            pending_results.delete();
            mismatch_count = 0;
            outstanding    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_THRESHOLD:   threshold_copy = cfg_data[THRESH_W-1:0];
                    REG_PASSTHROUGH: echo_on = cfg_data[0];
                    default:         ;
                endcase
            end
            if (in_valid && in_ready)
                absorb_sample(sample_in);
            if (out_valid && out_ready)
                check_result();
            outstanding = pending_results.size();
        end
    end

endmodule

@@ bench/tb_quadrature_correlation_detector_core.sv @@
`timescale 1ns / 1ps

module tb_quadrature_correlation_detector_core;
    import qcd_pkg::*;

    localparam int WINDOW           = 40;
    localparam int DRAIN_CYCLES     = 16;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SEGMENT_ITEMS    = 33;

    // Indexes past the register list; writes there must do nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam logic [THRESH_W-1:0]  THRESH_MAX  = '1;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       out_ready = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_in = '0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data  = '0;
    logic                       in_ready;
    logic                       out_valid;
    logic                       result_kind;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       detected;
    logic                       last_record;
    int                         mismatch_count;
    int                         outstanding;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit long_hold_req = 1'b0;

    quadrature_correlation_detector_core #(.WINDOW(WINDOW)) u_top (.*);

    quadrature_correlation_detector_checker #(.WINDOW(WINDOW)) u_checker (.*);

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("quadrature_correlation_detector_core verification failed");
        $finish;
    end

    // Receiver: random back-pressure, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one sample and hold it until the transaction completes
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= s;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop valid and wait until every expected result has arrived and the core is idle
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Mix quarter-rate tone runs (random amplitude, phase, light noise) with noise runs
    task automatic play_segment(input int count);
        int                         left;
        int                         run_len;
        int                         amp;
        int                         phase;
        int                         noise_amp;
        int                         v;
        logic signed [SAMPLE_W-1:0] s;
        left = count;
        while (left > 0)
        begin
            run_len = $urandom_range(40, 8);
            if (run_len > left)
                run_len = left;
            if ($urandom_range(99) < 70)
            begin
                amp       = $urandom_range(32767, 1500);
                phase     = $urandom_range(3);
                noise_amp = $urandom_range(amp / 8);
                for (int n = 0; n < run_len; n++)
                begin
                    case ((n + phase) % 4)
                        0:       v = amp;
                        2:       v = -amp;
                        default: v = 0;
                    endcase
                    v = v + int'($urandom_range(2 * noise_amp)) - noise_amp;
                    if (v > 32767)
                        v = 32767;
                    else if (v < -32768)
                        v = -32768;
                    s = SAMPLE_W'(v);
                    send_sample(s);
                end
            end
            else
            begin
                for (int n = 0; n < run_len; n++)
                begin
                    if ($urandom_range(1))
                        s = SAMPLE_W'($urandom());
                    else
                        s = SAMPLE_W'(int'($urandom_range(255)) - 128);
                    send_sample(s);
                end
            end
            left -= run_len;
        end
    endtask

    initial
    begin
        logic [THRESH_W-1:0] thr;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset registers, full-scale samples, boundary energies
        send_idle_pct = 10;
        recv_idle_pct = 30;
        send_sample(32767);
        settle();

        cfg_write(REG_PASSTHROUGH, 1);
        cfg_write(REG_THRESHOLD, THRESH_MAX);
        send_sample(-32768);
        send_sample(32767);
        send_sample(0);
        send_sample(-1);
        send_sample(1);
        send_sample(16'sh5555);
        send_sample(16'shaaaa);
        settle();

        // Zero threshold: first sample flushes the window, second has energy equal to it
        cfg_write(REG_THRESHOLD, '0);
        send_sample(0);
        send_sample(0);
        settle();

        // Only bit 0 of passthrough counts; energy equal to threshold, then one above
        cfg_write(REG_PASSTHROUGH, 2);
        cfg_write(REG_THRESHOLD, 1000000);
        send_sample(1000);
        settle();
        cfg_write(REG_THRESHOLD, 999999);
        send_sample(0);
        settle();

        // Writes to unused indexes must leave both registers alone
        cfg_write(REG_SPARE_A, '1);
        cfg_write(REG_SPARE_B, '1);
        cfg_write(REG_PASSTHROUGH, '1);
        send_sample(999);
        send_sample(-32768);

        // Random: three idle profiles, each with several register settings
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 24;
                    recv_idle_pct = 80;
                end
                1:
                begin
                    send_idle_pct = 80;
                    recv_idle_pct = 24;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 4; seg++)
            begin
                settle();
                case ($urandom_range(5))
                    0:       thr = '0;
                    1:       thr = THRESH_MAX;
                    2:       thr = THRESH_RESET;
                    3:       thr = THRESH_W'({$urandom(), $urandom()});
                    default: thr = (42'd1 << $urandom_range(38, 30)) + 42'($urandom());
                endcase
                cfg_write(REG_THRESHOLD, thr);
                cfg_write(REG_PASSTHROUGH, CFG_DATA_W'($urandom()));
                // Hold off the receiver while the sender keeps offering samples
                if (ph == 0 && seg == 1)
                    long_hold_req = 1'b1;
                play_segment(SEGMENT_ITEMS);
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("quadrature_correlation_detector_core verification clean");
        else
            $display("quadrature_correlation_detector_core verification failed");
        $finish;
    end

endmodule
